/* rtl/core/lamd_pkg.sv */
// Shared types and codes for the link announce and message deframer.
package lamd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned EV_W   = 2;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // Result event codes
  localparam logic [EV_W-1:0] EV_NAME = 2'd0;
  localparam logic [EV_W-1:0] EV_ADDR = 2'd1;
  localparam logic [EV_W-1:0] EV_CONN = 2'd2;
  localparam logic [EV_W-1:0] EV_MSG  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POSTAMBLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 2'd3;

  // Link phases
  localparam logic [1:0] PH_HUNT      = 2'd0;
  localparam logic [1:0] PH_ANNOUNCE  = 2'd1;
  localparam logic [1:0] PH_CONNECTED = 2'd2;

  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [BYTE_W-1:0] data_a;
    logic [BYTE_W-1:0] data_b;
    logic [POS_W-1:0]  position;
  } result_t;

endpackage

/* rtl/core/lamd_out_stage.sv */
// Result register with valid/stall handshake toward the consumer.
module lamd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lamd_pkg::result_t load_data,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output lamd_pkg::result_t out_data
);

  logic              valid_r;
  logic              valid_nxt;
  lamd_pkg::result_t data_r;

  // Upstream may transfer only when the held result is not stuck
  assign busy = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (!busy) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* rtl/core/link_announce_and_message_deframer.sv */
// Top level of the link announce and message deframer.
//
// One received byte is taken per cycle whenever the result register is free
// or its result is being transferred out in the same cycle; each byte is
// decoded in a single pass from the current state straight into the result
// register, so the block sustains one byte per clock and results appear in
// the cycle after the byte that caused them. The only throttle is downstream
// stall on a held result. After reset the block hunts for preamble_len fill
// bytes, then emits name and address characters with their positions, emits
// a connect event with both lengths after postamble_len fill bytes, and from
// then on pairs bytes into two-byte messages. Characters past NAME_CAP-1
// (name) or ADDR_CAP (address) are dropped silently.
module link_announce_and_message_deframer #(
  parameter int unsigned NAME_CAP = 49,
  parameter int unsigned ADDR_CAP = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_res,
  output logic [7:0] out_data_a,
  output logic [7:0] out_data_b,
  output logic [5:0] out_position
);

  localparam int unsigned NLW = (NAME_CAP > 1) ? $clog2(NAME_CAP) : 1;
  localparam int unsigned ALW = $clog2(ADDR_CAP + 1);
  localparam logic [NLW-1:0] NAME_MAX = NLW'(NAME_CAP - 1);
  localparam logic [ALW-1:0] ADDR_MAX = ALW'(ADDR_CAP);

  logic [7:0] fill_byte_r;
  logic [3:0] preamble_len_r;
  logic [3:0] postamble_len_r;
  logic [7:0] separator_byte_r;

  logic [1:0]     phase_r,          phase_nxt;
  logic [3:0]     run_count_r,      run_count_nxt;
  logic           name_done_r,      name_done_nxt;
  logic [NLW-1:0] name_length_r,    name_length_nxt;
  logic [ALW-1:0] address_length_r, address_length_nxt;
  logic [7:0]     held_byte_r,      held_byte_nxt;
  logic           half_message_r,   half_message_nxt;

  logic              accept;
  logic              busy;
  logic              emit;
  lamd_pkg::result_t res;
  lamd_pkg::result_t out_data;
  logic [3:0]        run_inc;
  logic              is_fill;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign run_inc  = run_count_r + 4'd1;
  assign is_fill  = (in_rx_byte == fill_byte_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_byte_r      <= 8'hFF;
      preamble_len_r   <= 4'd8;
      postamble_len_r  <= 4'd8;
      separator_byte_r <= 8'h22;
    end else if (cfg_we) begin
      case (cfg_index)
        lamd_pkg::CFG_FILL:      fill_byte_r      <= cfg_wdata;
        lamd_pkg::CFG_PREAMBLE:  preamble_len_r   <= cfg_wdata[3:0];
        lamd_pkg::CFG_POSTAMBLE: postamble_len_r  <= cfg_wdata[3:0];
        lamd_pkg::CFG_SEPARATOR: separator_byte_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt          = phase_r;
    run_count_nxt      = run_count_r;
    name_done_nxt      = name_done_r;
    name_length_nxt    = name_length_r;
    address_length_nxt = address_length_r;
    held_byte_nxt      = held_byte_r;
    half_message_nxt   = half_message_r;
    emit               = 1'b0;
    res.event_res      = lamd_pkg::EV_NAME;
    res.data_a         = in_rx_byte;
    res.data_b         = 8'd0;
    res.position       = '0;

    case (phase_r)
      lamd_pkg::PH_HUNT: begin
        if (is_fill) begin
          if (run_inc == preamble_len_r) begin
            run_count_nxt = 4'd0;
            phase_nxt     = lamd_pkg::PH_ANNOUNCE;
          end else begin
            run_count_nxt = run_inc;
          end
        end else begin
          run_count_nxt = 4'd0;
        end
      end
      lamd_pkg::PH_ANNOUNCE: begin
        if (is_fill) begin
          if (run_inc == postamble_len_r) begin
            run_count_nxt = 4'd0;
            phase_nxt     = lamd_pkg::PH_CONNECTED;
            emit          = 1'b1;
            res.event_res = lamd_pkg::EV_CONN;
            res.data_a    = 8'(name_length_r);
            res.data_b    = 8'(address_length_r);
          end else begin
            run_count_nxt = run_inc;
          end
        end else begin
          run_count_nxt = 4'd0;
          if (in_rx_byte == separator_byte_r) begin
            name_done_nxt = 1'b1;
          end else if (!name_done_r) begin
            if (name_length_r < NAME_MAX) begin
              name_length_nxt = name_length_r + NLW'(1);
              emit            = 1'b1;
              res.event_res   = lamd_pkg::EV_NAME;
              res.position    = lamd_pkg::POS_W'(name_length_r);
            end
          end else if (in_rx_byte != lamd_pkg::SPACE_CHAR &&
                       address_length_r < ADDR_MAX) begin
            address_length_nxt = address_length_r + ALW'(1);
            emit               = 1'b1;
            res.event_res      = lamd_pkg::EV_ADDR;
            res.position       = lamd_pkg::POS_W'(address_length_r);
          end
        end
      end
      lamd_pkg::PH_CONNECTED: begin
        if (!half_message_r) begin
          held_byte_nxt    = in_rx_byte;
          half_message_nxt = 1'b1;
        end else begin
          half_message_nxt = 1'b0;
          emit             = 1'b1;
          res.event_res    = lamd_pkg::EV_MSG;
          res.data_a       = held_byte_r;
          res.data_b       = in_rx_byte;
        end
      end
      default: begin
        phase_nxt = lamd_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= lamd_pkg::PH_HUNT;
      run_count_r      <= 4'd0;
      name_done_r      <= 1'b0;
      name_length_r    <= '0;
      address_length_r <= '0;
      held_byte_r      <= 8'd0;
      half_message_r   <= 1'b0;
    end else if (accept) begin
      phase_r          <= phase_nxt;
      run_count_r      <= run_count_nxt;
      name_done_r      <= name_done_nxt;
      name_length_r    <= name_length_nxt;
      address_length_r <= address_length_nxt;
      held_byte_r      <= held_byte_nxt;
      half_message_r   <= half_message_nxt;
    end
  end

  lamd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept && emit),
    .load_data (res),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_event_res = out_data.event_res;
  assign out_data_a    = out_data.data_a;
  assign out_data_b    = out_data.data_b;
  assign out_position  = out_data.position;

endmodule
